FILE: rtl/sipf_pkg.sv
// Shared types, constants and codes for the sorted interval point filter.
`timescale 1ns / 1ps
package sipf_pkg;
  localparam int NUM_CHROMS = 32;
  localparam int REGIONS_PER_CHROM = 256;
  localparam int CHROM_W = 5;
  localparam int CID_W = (NUM_CHROMS > 1) ? $clog2(NUM_CHROMS) : 1;
  localparam int IDX_W = (REGIONS_PER_CHROM > 1) ? $clog2(REGIONS_PER_CHROM) : 1;
  localparam int CNT_W = $clog2(REGIONS_PER_CHROM + 1);
  localparam int ADDR_W = CID_W + IDX_W;
  localparam int DEPTH = NUM_CHROMS * REGIONS_PER_CHROM;
  localparam int QD = 2;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_SELECTED = 3'd3;
  localparam logic [2:0] ST_NOT_SEL  = 3'd4;
  localparam logic [2:0] ST_NO_REG   = 3'd5;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic            action;
    logic            chrom_ok;
    logic [CHROM_W-1:0] chrom;
    logic [31:0]     left;
    logic [31:0]     right;
    logic [31:0]     pos;
  } cmd_t;
endpackage

FILE: rtl/sorted_interval_point_filter.sv
// Top level of the sorted interval point filter.
`timescale 1ns / 1ps
// Loads insert a region into its chromosome's sorted table; queries binary
// search that table and report containment. One item is handled at a time by
// the back end, which owns the region memory (one read and one write port). A
// query starts, then makes at most floor(log2(count))+1 probes, each a read
// and then a compare, and ends with the final test and the result. A stored
// load compares entries up to its place and moves every entry from its place
// on up, each move a read and then a write. A stalled result holds the back
// end until it is taken, and the command queue registers each item before the
// back end starts on it. A two-entry command queue lets the next item be taken
// meanwhile.
module sorted_interval_point_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [4:0]  chrom_id,
  input  logic [31:0] region_left,
  input  logic [31:0] region_right,
  input  logic [31:0] site_pos,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        covered,
  output logic [4:0]  chrom_echo,
  output logic [31:0] pos_echo
);
  import sipf_pkg::*;

  logic exclude_mode;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) exclude_mode <= 1'b0;
    else if (cfg_we) exclude_mode <= cfg_wdata;
  end

  sipf_front u_front (
    .clk, .rst, .valid(in_valid), .ready(in_ready), .action, .chrom_id,
    .region_left, .region_right, .site_pos, .cmd_valid, .cmd_ready, .cmd
  );

  sipf_back u_back (
    .clk, .rst, .exclude_mode, .cmd_valid, .cmd_ready, .cmd, .out_valid,
    .out_ready, .status, .covered, .chrom_echo, .pos_echo
  );

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_NO_REG)) else $error("status code out of range");
  a_cov_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_STORED || status == ST_DUP || status == ST_FULL ||
    status == ST_NO_REG) |-> !covered) else $error("covered set without a query");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped while stalled");
endmodule

FILE: rtl/sipf_front.sv
// Front end: accepts items, checks the chromosome range and queues commands.
`timescale 1ns / 1ps
module sipf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid,
  output logic                   ready,
  input  logic                   action,
  input  logic [4:0]             chrom_id,
  input  logic [31:0]            region_left,
  input  logic [31:0]            region_right,
  input  logic [31:0]            site_pos,
  output logic                   cmd_valid,
  input  logic                   cmd_ready,
  output sipf_pkg::cmd_t         cmd
);
  import sipf_pkg::*;

  cmd_t q [QD];
  logic rd_ptr;
  logic wr_ptr;
  logic [1:0] fill;
  cmd_t incoming;
  logic push;
  logic pop;

  always_comb begin
    incoming.action   = action;
    incoming.chrom_ok = ({27'd0, chrom_id} < 32'(NUM_CHROMS));
    incoming.chrom    = chrom_id;
    incoming.left     = region_left;
    incoming.right    = region_right;
    incoming.pos      = site_pos;
  end

  assign ready     = (fill != 2'(QD));
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = valid && ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/sipf_back.sv
// Back end: sorted insertion and binary search over the region memory.
`timescale 1ns / 1ps
module sipf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              exclude_mode,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  sipf_pkg::cmd_t    cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic              covered,
  output logic [4:0]        chrom_echo,
  output logic [31:0]       pos_echo
);
  import sipf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFTR = 3'd2;
  localparam logic [2:0] S_SHIFTW = 3'd3;
  localparam logic [2:0] S_SRCH   = 3'd4;
  localparam logic [2:0] S_TEST   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [63:0] wdata;
  logic we;

  logic [CNT_W-1:0] counts [NUM_CHROMS];
  logic [2:0] state;
  cmd_t cur;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] p;
  logic [CNT_W-1:0] k;
  logic [CNT_W:0] lo;
  logic [CNT_W:0] hi;
  logic [CNT_W-1:0] mid;
  logic [63:0] key;
  logic [CID_W-1:0] cid;
  logic [31:0] rl;
  logic [31:0] rr;

  assign cid = cur.chrom[CID_W-1:0];
  assign key = {cur.left, cur.right};
  assign rl = rdata[63:32];
  assign rr = rdata[31:0];
  assign cmd_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // One memory read is issued per cycle; its data is used in the next cycle.
  always_comb begin
    raddr = {cid, p[IDX_W-1:0]};
    we    = 1'b0;
    waddr = {cid, k[IDX_W-1:0]};
    wdata = rdata;
    unique case (state)
      S_SCAN:   raddr = {cid, p[IDX_W-1:0]};
      S_SHIFTR: raddr = {cid, IDX_W'(k - CNT_W'(1))};
      S_SHIFTW: begin
        we = 1'b1;
        if (k == p) wdata = key;
      end
      S_SRCH:   raddr = {cid, mid[IDX_W-1:0]};
      default:  raddr = {cid, p[IDX_W-1:0]};
    endcase
  end

  logic pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pending <= 1'b0;
      for (int i = 0; i < NUM_CHROMS; i++) counts[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd_valid) begin
          cur <= cmd;
          covered <= 1'b0;
          chrom_echo <= cmd.chrom;
          pos_echo <= (cmd.action == ACT_QUERY) ? cmd.pos : cmd.left;
          n <= counts[cmd.chrom[CID_W-1:0]];
          p <= '0;
          pending <= 1'b0;
          lo <= '0;
          if (!cmd.chrom_ok) begin
            status <= (cmd.action == ACT_QUERY) ? ST_NO_REG : ST_FULL;
            state <= S_OUT;
          end else if (cmd.action == ACT_QUERY) begin
            if (counts[cmd.chrom[CID_W-1:0]] == '0) begin
              status <= ST_NO_REG;
              state <= S_OUT;
            end else begin
              hi <= {1'b0, counts[cmd.chrom[CID_W-1:0]]} - (CNT_W+1)'(1);
              mid <= CNT_W'(({1'b0, counts[cmd.chrom[CID_W-1:0]]}
                     - (CNT_W+1)'(1)) >> 1);
              state <= S_SRCH;
            end
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Read of entry p was issued last cycle when pending is set.
          if (!pending) begin
            if (p >= n) begin
              if (n >= CNT_W'(REGIONS_PER_CHROM)) begin
                status <= ST_FULL;
                state <= S_OUT;
              end else begin
                k <= n;
                state <= (n == p) ? S_SHIFTW : S_SHIFTR;
              end
            end else pending <= 1'b1;
          end else begin
            pending <= 1'b0;
            if (rdata < key) p <= p + CNT_W'(1);
            else if (rdata == key) begin
              status <= ST_DUP;
              state <= S_OUT;
            end else if (n >= CNT_W'(REGIONS_PER_CHROM)) begin
              status <= ST_FULL;
              state <= S_OUT;
            end else begin
              k <= n;
              state <= S_SHIFTR;
            end
          end
        end
        S_SHIFTR: state <= S_SHIFTW;
        S_SHIFTW: begin
          if (k == p) begin
            counts[cid] <= n + CNT_W'(1);
            status <= ST_STORED;
            state <= S_OUT;
          end else begin
            k <= k - CNT_W'(1);
            state <= (k - CNT_W'(1) == p) ? S_SHIFTW : S_SHIFTR;
          end
        end
        S_SRCH: begin
          if (!pending) pending <= 1'b1;
          else begin
            pending <= 1'b0;
            if (cur.pos < rl) begin
              if ({1'b0, mid} == '0 || {1'b0, mid} - (CNT_W+1)'(1) < lo) state <= S_TEST;
              else begin
                hi <= {1'b0, mid} - (CNT_W+1)'(1);
                mid <= CNT_W'((lo + {1'b0, mid} - (CNT_W+1)'(1)) >> 1);
              end
            end else if (cur.pos > rr) begin
              if ({1'b0, mid} + (CNT_W+1)'(1) > hi) state <= S_TEST;
              else begin
                lo <= {1'b0, mid} + (CNT_W+1)'(1);
                mid <= CNT_W'(({1'b0, mid} + (CNT_W+1)'(1) + hi) >> 1);
              end
            end else state <= S_TEST;
          end
        end
        S_TEST: begin
          covered <= (cur.pos >= rl) && (cur.pos <= rr);
          status <= (((cur.pos >= rl) && (cur.pos <= rr)) ^ exclude_mode)
                    ? ST_SELECTED : ST_NOT_SEL;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sim/sipf_checker.sv
// Checker for the sorted interval point filter: predicts and compares every result.
`timescale 1ns / 1ps
module sipf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        action,
  input  logic [4:0]  chrom_id,
  input  logic [31:0] region_left,
  input  logic [31:0] region_right,
  input  logic [31:0] site_pos,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic        covered,
  input  logic [4:0]  chrom_echo,
  input  logic [31:0] pos_echo,
  output int          errors,
  output int          pending
);
  import sipf_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic        covered;
    logic [4:0]  chrom;
    logic [31:0] pos;
  } answer_t;

  logic [63:0] region_tbl [NUM_CHROMS][REGIONS_PER_CHROM];
  int          region_cnt [NUM_CHROMS];
  logic        exclude_mode;
  answer_t     answers_due [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [2:0] insert_region(input int c, input logic [31:0] l,
                                               input logic [31:0] r);
    logic [63:0] key;
    int          n;
    int          p;
    key = {l, r};
    n = region_cnt[c];
    p = 0;
    while (p < n && region_tbl[c][p] < key) p++;
    if (p < n && region_tbl[c][p] == key) return ST_DUP;
    if (n >= REGIONS_PER_CHROM) return ST_FULL;
    for (int k = n; k > p; k--) region_tbl[c][k] = region_tbl[c][k-1];
    region_tbl[c][p] = key;
    region_cnt[c] = n + 1;
    return ST_STORED;
  endfunction

  // Only the interval at the last probe is tested for containment.
  function automatic answer_t search_site(input int c, input logic [31:0] s);
    answer_t     a;
    int          lo;
    int          hi;
    int          mid;
    logic [31:0] l;
    logic [31:0] r;
    a = '0;
    a.chrom = c[4:0];
    a.pos = s;
    if (region_cnt[c] == 0) begin
      a.status = ST_NO_REG;
      return a;
    end
    lo = 0;
    hi = region_cnt[c] - 1;
    mid = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      l = region_tbl[c][mid][63:32];
      r = region_tbl[c][mid][31:0];
      if (s < l) hi = mid - 1;
      else if (s > r) lo = mid + 1;
      else break;
    end
    l = region_tbl[c][mid][63:32];
    r = region_tbl[c][mid][31:0];
    a.covered = (s >= l) && (s <= r);
    a.status = (a.covered ^ exclude_mode) ? ST_SELECTED : ST_NOT_SEL;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t a;
    answer_t want;
    if (rst) begin
      for (int c = 0; c < NUM_CHROMS; c++) region_cnt[c] = 0;
      exclude_mode = 1'b0;
      answers_due.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_we) exclude_mode = cfg_wdata;
      if (in_valid && in_ready) begin
        if (action == ACT_LOAD) begin
          a = '0;
          a.chrom = chrom_id;
          a.pos = region_left;
          a.status = (int'(chrom_id) < NUM_CHROMS) ?
                     insert_region(int'(chrom_id), region_left, region_right) : ST_FULL;
        end else if (int'(chrom_id) < NUM_CHROMS) begin
          a = search_site(int'(chrom_id), site_pos);
        end else begin
          a = '0;
          a.chrom = chrom_id;
          a.pos = site_pos;
          a.status = ST_NO_REG;
        end
        answers_due.insert(answers_due.size(), a);
      end
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = answers_due.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (covered !== want.covered)
            report_mismatch($sformatf("covered %0b, expected %0b", covered, want.covered));
          if (chrom_echo !== want.chrom)
            report_mismatch($sformatf("chrom_echo %0d, expected %0d", chrom_echo, want.chrom));
          if (pos_echo !== want.pos)
            report_mismatch($sformatf("pos_echo %h, expected %h", pos_echo, want.pos));
        end
      end
      pending = answers_due.size();
    end
  end
endmodule

FILE: sim/tb_sorted_interval_point_filter.sv
// Testbench top for the sorted interval point filter: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_sorted_interval_point_filter;
  import sipf_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [4:0]  chrom_id;
  logic [31:0] region_left;
  logic [31:0] region_right;
  logic [31:0] site_pos;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic        covered;
  logic [4:0]  chrom_echo;
  logic [31:0] pos_echo;
  int          errors;
  int          pending;
  int          cycles;
  int          idle_pct;
  int          stall_pct;
  logic [68:0] loaded [$];

  sorted_interval_point_filter i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .chrom_id(chrom_id),
    .region_left(region_left), .region_right(region_right), .site_pos(site_pos),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .covered(covered),
    .chrom_echo(chrom_echo), .pos_echo(pos_echo)
  );

  sipf_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .chrom_id(chrom_id),
    .region_left(region_left), .region_right(region_right), .site_pos(site_pos),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .covered(covered),
    .chrom_echo(chrom_echo), .pos_echo(pos_echo), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      cycles <= 0;
      out_ready <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      out_ready <= ($urandom_range(1, 100) > stall_pct);
    end
    if (cycles > 3000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // in_ready only moves on a clock edge, so its value at the falling edge is the
  // one seen at the next rising edge.
  task automatic send(input logic a, input logic [4:0] c, input logic [31:0] l,
                      input logic [31:0] r, input logic [31:0] s);
    logic rdy;
    if ($urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    chrom_id <= c;
    region_left <= l;
    region_right <= r;
    site_pos <= s;
    if (a == ACT_LOAD) loaded.insert(loaded.size(), {c, l, r});
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] coord();
    int k;
    k = $urandom_range(0, 99);
    if (k < 8) return $urandom();
    if (k < 10) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    if (k < 12) return $urandom_range(0, 3);
    return $urandom_range(0, 3000);
  endfunction

  task automatic random_item();
    logic [4:0]  c;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] s;
    logic [68:0] pick;
    c = ($urandom_range(0, 99) < 70) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < 40) begin
      l = coord();
      if ($urandom_range(0, 99) < 6) r = l - $urandom_range(1, 40);
      else if (l[31]) r = $urandom();
      else r = l + $urandom_range(0, 60);
      if (loaded.size() != 0 && $urandom_range(0, 99) < 8) begin
        pick = loaded[$urandom_range(0, loaded.size() - 1)];
        {c, l, r} = pick;
      end
      send(ACT_LOAD, c, l, r, $urandom());
    end else begin
      s = coord();
      if (loaded.size() != 0 && $urandom_range(0, 99) < 65) begin
        pick = loaded[$urandom_range(0, loaded.size() - 1)];
        c = pick[68:64];
        case ($urandom_range(0, 4))
          0: s = pick[63:32];
          1: s = pick[31:0];
          2: s = pick[63:32] - 1;
          3: s = pick[31:0] + 1;
          default: s = pick[63:32] + (pick[31:0] - pick[63:32]) / 2;
        endcase
      end
      send(ACT_QUERY, c, $urandom(), $urandom(), s);
    end
  endtask

  task automatic directed_items();
    send(ACT_LOAD, 0, 100, 200, 0);
    send(ACT_LOAD, 0, 100, 200, 0);
    send(ACT_LOAD, 0, 300, 250, 0);
    send(ACT_LOAD, 0, 0, 0, 32'hFFFF_FFFF);
    send(ACT_LOAD, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send(ACT_LOAD, 0, 100, 150, 0);
    send(ACT_LOAD, 31, 0, 32'hFFFF_FFFF, 0);
    send(ACT_QUERY, 0, 0, 0, 150);
    send(ACT_QUERY, 0, 0, 0, 99);
    send(ACT_QUERY, 0, 0, 0, 201);
    send(ACT_QUERY, 0, 0, 0, 0);
    send(ACT_QUERY, 0, 0, 0, 32'hFFFF_FFFF);
    send(ACT_QUERY, 0, 0, 0, 275);
    send(ACT_QUERY, 30, 0, 0, 5);
    send(ACT_QUERY, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12345);
    send(ACT_QUERY, 31, 0, 0, 32'hFFFF_FFFF);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    action = ACT_LOAD;
    chrom_id = '0;
    region_left = '0;
    region_right = '0;
    site_pos = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    set_mode(1'b1);
    directed_items();

    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0]);
      idle_pct = (ph == 1 || ph == 3) ? 56 : (ph == 2 ? 19 : 0);
      stall_pct = (ph == 2 || ph == 3) ? 56 : (ph == 1 ? 19 : 0);
      if (ph == 1) begin
        // Fill one table in ascending order, then overflow it and repeat an entry.
        for (int i = 0; i < REGIONS_PER_CHROM; i++)
          send(ACT_LOAD, 7, 100000 + i * 10, 100005 + i * 10, 0);
        send(ACT_LOAD, 7, 5, 6, 0);
        send(ACT_LOAD, 7, 100010, 100015, 0);
        send(ACT_QUERY, 7, 0, 0, 100003);
        send(ACT_QUERY, 7, 0, 0, 100007);
      end
      for (int i = 0; i < 120; i++) begin
        if (ph == 2 && i == 60) drain();
        random_item();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/sipf_pkg.sv
rtl/sipf_front.sv
rtl/sipf_back.sv
rtl/sorted_interval_point_filter.sv
sim/sipf_checker.sv
sim/tb_sorted_interval_point_filter.sv
